FILE: sv/mdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_pkg
// Shared constants and types of the multiscale descriptor pool: pooling mode
// codes, accumulator widths, the job word that goes from front to back, and
// the state type of the back end.
// ----------------------------------------------------------------------------
package mdp_pkg;

  // Fixed field widths of the ports
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned WPORT_BITS  = 16;
  localparam int unsigned MODE_BITS   = 3;

  // Accumulator widths
  localparam int unsigned TOTAL_BITS  = 56;
  localparam int unsigned WSUM_BITS   = 20;
  localparam int unsigned PROD_BITS   = 49;

  // Parameter defaults
  localparam int unsigned DEF_VALUE_BITS  = 32;
  localparam int unsigned DEF_WEIGHT_BITS = 16;

  // Weight 1.0 in Q4.12
  localparam logic [WPORT_BITS-1:0] ONE_Q12 = 16'd4096;

  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  // Restoring divider: one quotient bit per step
  localparam int unsigned DIV_STEPS    = TOTAL_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

  // Pooling mode codes
  localparam logic [MODE_BITS-1:0] MODE_AVG  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_WAVG = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_MAX  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_MIN  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_CAT  = 3'd4;

  typedef enum logic [2:0] {
    JOB_PASS,
    JOB_REL,
    JOB_EXT,
    JOB_REF,
    JOB_DIV
  } job_kind_t;

  typedef struct packed {
    job_kind_t                     kind;
    logic signed [TOTAL_BITS-1:0]  num;
    logic [WSUM_BITS-1:0]          den;
    logic signed [DATA_BITS-1:0]   val;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

FILE: sv/mdp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_front
// Front end: accepts items, forms value times weight, and keeps the run
// accumulators. Emits one job per finished run, or per item in concatenate
// mode.
// ----------------------------------------------------------------------------
module mdp_front #(
  parameter int unsigned VALUE_BITS  = mdp_pkg::DEF_VALUE_BITS,
  parameter int unsigned WEIGHT_BITS = mdp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [mdp_pkg::MODE_BITS-1:0]          agg_mode,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mdp_pkg::DATA_BITS-1:0]   in_element_value,
  input  logic [mdp_pkg::WPORT_BITS-1:0]         in_scale_weight,
  input  logic                                   in_first_scale,
  input  logic                                   in_last_scale,
  input  logic                                   in_shape_matches,
  output logic                                   q_push,
  output mdp_pkg::job_t                          q_job,
  input  logic                                   q_full
);

  localparam int unsigned VSHIFT = mdp_pkg::DATA_BITS - VALUE_BITS;
  localparam logic [mdp_pkg::WPORT_BITS-1:0] WMASK =
    mdp_pkg::WPORT_BITS'((32'd1 << WEIGHT_BITS) - 32'd1);

  // Stage 1: captured item and product
  logic                                   s1_vld_r, s1_vld_nxt;
  logic signed [mdp_pkg::DATA_BITS-1:0]   s1_val_r;
  logic signed [mdp_pkg::PROD_BITS-1:0]   s1_prod_r;
  logic [mdp_pkg::WPORT_BITS-1:0]         s1_eff_r;
  logic                                   s1_first_r, s1_last_r, s1_match_r;
  logic [mdp_pkg::MODE_BITS-1:0]          s1_mode_r;

  // Run state
  logic signed [mdp_pkg::TOTAL_BITS-1:0]  rt_r, rt_nxt;
  logic [mdp_pkg::WSUM_BITS-1:0]          wt_r, wt_nxt;
  logic signed [mdp_pkg::DATA_BITS-1:0]   ref_r, ref_nxt;
  logic                                   mis_r, mis_nxt;

  logic                                   accept;
  logic [mdp_pkg::DATA_BITS-1:0]          v_shl;
  logic signed [mdp_pkg::DATA_BITS-1:0]   v_sext;
  logic [mdp_pkg::WPORT_BITS-1:0]         eff;
  logic signed [mdp_pkg::PROD_BITS-1:0]   prod;

  logic                                   s1_ext, s1_cat, need_push, s1_adv;
  logic signed [mdp_pkg::TOTAL_BITS-1:0]  val56, rt_a, rt_b;
  logic [mdp_pkg::WSUM_BITS-1:0]          wt_a, wt_b;
  logic signed [mdp_pkg::DATA_BITS-1:0]   ref_a;
  logic                                   mis_a;
  logic [mdp_pkg::TOTAL_BITS:0]           sum57;
  logic [mdp_pkg::WSUM_BITS:0]            wsum21;

  // Accept side: sign-extend the value, pick the weight, multiply
  assign accept = in_valid && in_ready;
  assign v_shl  = in_element_value << VSHIFT;
  assign v_sext = $signed(v_shl) >>> VSHIFT;
  assign eff    = (agg_mode == mdp_pkg::MODE_WAVG) ? (in_scale_weight & WMASK)
                                                   : mdp_pkg::ONE_Q12;
  assign prod   = $signed({{(mdp_pkg::PROD_BITS-mdp_pkg::DATA_BITS){v_sext[31]}}, v_sext})
                * $signed({{(mdp_pkg::PROD_BITS-mdp_pkg::WPORT_BITS){1'b0}}, eff});

  // Stage 2: update the run
  assign s1_ext    = (s1_mode_r == mdp_pkg::MODE_MAX) || (s1_mode_r == mdp_pkg::MODE_MIN);
  assign s1_cat    = (s1_mode_r == mdp_pkg::MODE_CAT);
  assign need_push = s1_cat || s1_last_r;
  assign s1_adv    = s1_vld_r && (!need_push || !q_full);
  assign q_push    = s1_vld_r && need_push && !q_full;
  assign in_ready  = !s1_vld_r || s1_adv;
  assign val56     = $signed({{(mdp_pkg::TOTAL_BITS-mdp_pkg::DATA_BITS){s1_val_r[31]}},
                              s1_val_r});

  always_comb begin
    rt_a  = rt_r;
    wt_a  = wt_r;
    ref_a = ref_r;
    mis_a = mis_r;
    if (s1_first_r) begin
      rt_a  = '0;
      wt_a  = '0;
      ref_a = s1_val_r;
      mis_a = 1'b0;
      if (s1_ext) begin
        rt_a = val56;
      end
    end else if (s1_mode_r == mdp_pkg::MODE_MAX) begin
      if (val56 > rt_r) begin
        rt_a = val56;
      end
    end else if (s1_mode_r == mdp_pkg::MODE_MIN) begin
      if (val56 < rt_r) begin
        rt_a = val56;
      end
    end
    if (!s1_match_r) begin
      mis_a = 1'b1;
    end

    sum57  = {rt_a[mdp_pkg::TOTAL_BITS-1], rt_a}
           + {{(mdp_pkg::TOTAL_BITS+1-mdp_pkg::PROD_BITS){s1_prod_r[mdp_pkg::PROD_BITS-1]}},
              s1_prod_r};
    wsum21 = {1'b0, wt_a} + {{(mdp_pkg::WSUM_BITS+1-mdp_pkg::WPORT_BITS){1'b0}}, s1_eff_r};
    rt_b   = rt_a;
    wt_b   = wt_a;
    // Average modes: skip zero weights, saturate both sums
    if (!s1_ext && (s1_eff_r != '0)) begin
      if (sum57[mdp_pkg::TOTAL_BITS] != sum57[mdp_pkg::TOTAL_BITS-1]) begin
        rt_b = sum57[mdp_pkg::TOTAL_BITS] ? mdp_pkg::TOTAL_MIN : mdp_pkg::TOTAL_MAX;
      end else begin
        rt_b = $signed(sum57[mdp_pkg::TOTAL_BITS-1:0]);
      end
      wt_b = wsum21[mdp_pkg::WSUM_BITS] ? '1 : wsum21[mdp_pkg::WSUM_BITS-1:0];
    end
  end

  // Job for the back end
  always_comb begin
    q_job.num  = rt_b;
    q_job.den  = wt_b;
    q_job.val  = ref_a;
    if (s1_cat) begin
      q_job.kind = mdp_pkg::JOB_PASS;
      q_job.val  = s1_val_r;
    end else if (mis_a) begin
      q_job.kind = mdp_pkg::JOB_REL;
    end else if (s1_ext) begin
      q_job.kind = mdp_pkg::JOB_EXT;
    end else if (wt_b == '0) begin
      q_job.kind = mdp_pkg::JOB_REF;
    end else begin
      q_job.kind = mdp_pkg::JOB_DIV;
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    rt_nxt  = rt_r;
    wt_nxt  = wt_r;
    ref_nxt = ref_r;
    mis_nxt = mis_r;
    if (s1_adv && !s1_cat) begin
      if (s1_last_r) begin
        rt_nxt  = '0;
        wt_nxt  = '0;
        ref_nxt = '0;
        mis_nxt = 1'b0;
      end else begin
        rt_nxt  = rt_b;
        wt_nxt  = wt_b;
        ref_nxt = ref_a;
        mis_nxt = mis_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      rt_r     <= '0;
      wt_r     <= '0;
      ref_r    <= '0;
      mis_r    <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      rt_r     <= rt_nxt;
      wt_r     <= wt_nxt;
      ref_r    <= ref_nxt;
      mis_r    <= mis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_val_r   <= v_sext;
      s1_prod_r  <= prod;
      s1_eff_r   <= eff;
      s1_first_r <= in_first_scale;
      s1_last_r  <= in_last_scale;
      s1_match_r <= in_shape_matches;
      s1_mode_r  <= agg_mode;
    end
  end

endmodule

FILE: sv/mdp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_queue
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
module mdp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mdp_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output mdp_pkg::job_t  head_job,
  output logic           empty
);

  mdp_pkg::job_t head_r, head_nxt;
  mdp_pkg::job_t tail_r, tail_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_job = head_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_nxt = push_job;
        end else begin
          tail_nxt = push_job;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        // only reachable with one entry: replace it
        if (cnt_r == 2'd1) begin
          head_nxt = push_job;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_job;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

FILE: sv/mdp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_back
// Back end: turns jobs into results. Averages go through a restoring
// divider, one quotient bit per cycle, with round-to-nearest and saturation.
// ----------------------------------------------------------------------------
module mdp_back #(
  parameter int unsigned VALUE_BITS = mdp_pkg::DEF_VALUE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mdp_pkg::job_t                         q_job,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mdp_pkg::DATA_BITS-1:0]  out_pooled_value,
  output logic                                  out_released
);

  localparam int unsigned TB = mdp_pkg::TOTAL_BITS;
  localparam int unsigned WB = mdp_pkg::WSUM_BITS;
  localparam logic [TB-1:0] VHI_U = (TB'(1) << (VALUE_BITS - 1)) - TB'(1);
  localparam logic [TB-1:0] VLO_U = VHI_U + TB'(1);
  localparam logic signed [TB-1:0] VHI = $signed(VHI_U);
  localparam logic signed [TB-1:0] VLO = -VHI - TB'(1);

  mdp_pkg::back_state_t state_r, state_nxt;

  logic                              out_vld_r;
  logic signed [mdp_pkg::DATA_BITS-1:0] out_val_r;
  logic                              out_rel_r;

  logic [TB-1:0]                     dvd_r;
  logic [WB-1:0]                     rem_r;
  logic [WB-1:0]                     den_r;
  logic                              neg_r;
  logic [mdp_pkg::DIV_CNT_BITS-1:0]  cnt_r;

  logic                              out_free;
  logic                              ld_out, ld_rel, div_start, div_step;
  logic signed [mdp_pkg::DATA_BITS-1:0] ld_val;
  logic signed [mdp_pkg::DATA_BITS-1:0] job_res, fin_res;
  logic signed [TB-1:0]              ext_sat;
  logic                              job_neg;
  logic [TB-1:0]                     dvd_init;
  logic [WB:0]                       rem_sh;
  logic [WB+1:0]                     diff;
  logic                              qbit;

  assign out_free = !out_vld_r || out_ready;

  // Results that need no division
  always_comb begin
    if (q_job.num > VHI) begin
      ext_sat = VHI;
    end else if (q_job.num < VLO) begin
      ext_sat = VLO;
    end else begin
      ext_sat = q_job.num;
    end
    case (q_job.kind)
      mdp_pkg::JOB_REL: job_res = '0;
      mdp_pkg::JOB_EXT: job_res = ext_sat[mdp_pkg::DATA_BITS-1:0];
      default:          job_res = q_job.val;
    endcase
  end

  // Divider setup: magnitude plus half the divisor
  assign job_neg  = q_job.num[TB-1];
  assign dvd_init = (job_neg ? ~q_job.num : q_job.num)
                  + {{(TB-WB+1){1'b0}}, q_job.den[WB-1:1]}
                  + {{(TB-1){1'b0}}, job_neg};

  // One restoring step
  assign rem_sh = {rem_r, dvd_r[TB-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign qbit   = !diff[WB+1];

  // Saturate and sign the quotient
  always_comb begin
    if (!neg_r) begin
      fin_res = (dvd_r > VHI_U) ? VHI[mdp_pkg::DATA_BITS-1:0]
                                : dvd_r[mdp_pkg::DATA_BITS-1:0];
    end else begin
      fin_res = (dvd_r > VLO_U) ? VLO[mdp_pkg::DATA_BITS-1:0]
                                : -dvd_r[mdp_pkg::DATA_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdp_pkg::BK_IDLE: begin
        if (!q_empty && (q_job.kind == mdp_pkg::JOB_DIV)) begin
          state_nxt = mdp_pkg::BK_DIV;
        end
      end
      mdp_pkg::BK_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = mdp_pkg::BK_FIN;
        end
      end
      mdp_pkg::BK_FIN: begin
        if (out_free) begin
          state_nxt = mdp_pkg::BK_IDLE;
        end
      end
      default: state_nxt = mdp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ld_out    = 1'b0;
    ld_val    = job_res;
    ld_rel    = 1'b0;
    div_start = 1'b0;
    div_step  = 1'b0;
    unique case (state_r)
      mdp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_job.kind == mdp_pkg::JOB_DIV) begin
            q_pop     = 1'b1;
            div_start = 1'b1;
          end else if (out_free) begin
            q_pop  = 1'b1;
            ld_out = 1'b1;
            ld_rel = (q_job.kind == mdp_pkg::JOB_REL);
          end
        end
      end
      mdp_pkg::BK_DIV: begin
        div_step = 1'b1;
      end
      mdp_pkg::BK_FIN: begin
        ld_out = out_free;
        ld_val = fin_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mdp_pkg::BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_val_r <= ld_val;
      out_rel_r <= ld_rel;
    end
    if (div_start) begin
      dvd_r <= dvd_init;
      rem_r <= '0;
      den_r <= q_job.den;
      neg_r <= job_neg;
      cnt_r <= mdp_pkg::DIV_CNT_BITS'(mdp_pkg::DIV_STEPS - 1);
    end else if (div_step) begin
      dvd_r <= {dvd_r[TB-2:0], qbit};
      rem_r <= qbit ? diff[WB-1:0] : rem_sh[WB-1:0];
      cnt_r <= cnt_r - mdp_pkg::DIV_CNT_BITS'(1);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pooled_value = out_val_r;
  assign out_released     = out_rel_r;

endmodule

FILE: sv/multiscale_descriptor_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiscale_descriptor_pool
// Pools one descriptor element across scales: average, weighted average,
// maximum, minimum, or concatenate passthrough.
// ----------------------------------------------------------------------------
// Feed items element-major, one per scale, flag the first and last item of
// each run; one result comes out per run (per item in concatenate mode). The
// front end takes one item per cycle unless a finished run waits on a full
// queue: it registers value times weight, then adds it into a saturating
// 56-bit sum and a 20-bit weight sum (or tracks the extreme). A finished run
// goes as a job into a two-entry queue. The back end loads released, extreme,
// reference and passthrough results straight into its output register; an
// average result runs through a restoring divider at one quotient bit per
// cycle, so a stream of averaged runs is paced by the divider, while the front
// end keeps accumulating later runs into the queue. Results are rounded to
// nearest, ties away from zero, and saturated to VALUE_BITS.
// The mode register is sampled with each item; change it only while idle.
// ----------------------------------------------------------------------------
module multiscale_descriptor_pool #(
  parameter int unsigned VALUE_BITS  = mdp_pkg::DEF_VALUE_BITS,
  parameter int unsigned WEIGHT_BITS = mdp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [mdp_pkg::MODE_BITS-1:0]         cfg_wr_data,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mdp_pkg::DATA_BITS-1:0]  in_element_value,
  input  logic [mdp_pkg::WPORT_BITS-1:0]        in_scale_weight,
  input  logic                                  in_first_scale,
  input  logic                                  in_last_scale,
  input  logic                                  in_shape_matches,
  // results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mdp_pkg::DATA_BITS-1:0]  out_pooled_value,
  output logic                                  out_released
);

  // Pooling mode register
  logic [mdp_pkg::MODE_BITS-1:0] agg_mode_r;

  // Front to queue, queue to back
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  mdp_pkg::job_t  push_job;
  mdp_pkg::job_t  head_job;

  // Hold the mode until the next write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agg_mode_r <= mdp_pkg::MODE_AVG;
    end else if (cfg_wr_en) begin
      agg_mode_r <= cfg_wr_data;
    end
  end

  // Accept, multiply, accumulate
  mdp_front #(
    .VALUE_BITS  (VALUE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .agg_mode         (agg_mode_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .in_scale_weight  (in_scale_weight),
    .in_first_scale   (in_first_scale),
    .in_last_scale    (in_last_scale),
    .in_shape_matches (in_shape_matches),
    .q_push           (q_push),
    .q_job            (push_job),
    .q_full           (q_full)
  );

  // Decouple run accumulation from division
  mdp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  // Divide, round, saturate, deliver
  mdp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_job            (head_job),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_released     (out_released)
  );

`ifndef SYNTHESIS
  // A voided result always carries a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_released |-> out_pooled_value == '0)
    else $error("released result with nonzero value");

  // The front never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // The back never pops an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // Reset leaves no result pending
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
